/* rtl/ple_pkg.sv */
package ple_pkg;

  localparam int unsigned DEPTH_DEF       = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_LOCATE = 3'd3,
    REQ_SORT   = 3'd4,
    REQ_SHOW   = 3'd5,
    REQ_CLEAR  = 3'd6
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_LOC_RD,
    ST_LOC_CMP,
    ST_SRT_I,
    ST_SRT_LD,
    ST_SRT_RD,
    ST_SRT_CMP,
    ST_SHW_RD,
    ST_SHW_EMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] element;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } out_beat_t;

endpackage

/* rtl/positional_list_engine_core.sv */
// Channel | Direction | Handshake                    | Payload
// in      | input     | in_valid_i / in_stall_o      | in_beat_i  (ple_pkg::in_beat_t)
// out     | output    | out_valid_o / out_stall_i    | out_beat_o (ple_pkg::out_beat_t)
//
// One request is in flight at a time; in_stall_o stays high until its last result beat
// is loaded into the output register. Append, clear, refused requests and the unused
// type go straight to the result beat. Insert moves elements up one place from the end,
// delete moves them down one place from the position, locate scans from the first
// element, sort orders the list by signed value, smallest first, and show emits one
// beat per element (a single beat when empty). Each step is paced by the single
// element memory, which has one read port and registered read data.
// Reset empties the list; the element memory itself is not cleared.
module positional_list_engine_core #(
  parameter int unsigned DEPTH       = ple_pkg::DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = ple_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ple_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ple_pkg::out_beat_t out_beat_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;
  localparam int unsigned EW = (VALUE_WIDTH > ple_pkg::VAL_W) ? VALUE_WIDTH : ple_pkg::VAL_W;

  ple_pkg::state_e state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          i_q, i_d;
  logic [CW-1:0]          j_q, j_d;
  logic [CW-1:0]          pos_q, pos_d;
  logic [CW-1:0]          fpos_q, fpos_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [VALUE_WIDTH-1:0] cur_q, cur_d;
  ple_pkg::status_e       status_q, status_d;
  logic                   out_valid_q, out_valid_d;
  ple_pkg::out_beat_t     out_beat_q, out_beat_d;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];
  logic [VALUE_WIDTH-1:0] mem_rdata_q;
  logic                   mem_we, mem_re;
  logic [CW-1:0]          mem_waddr, mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;

  logic [EW-1:0]          val_in_ext;
  logic signed [EW-1:0]   elem_ext;
  logic [WW-1:0]          pos_in_w, count_w;
  logic                   out_free;
  logic                   in_take;
  logic                   cur_greater;

  assign in_stall_o  = (state_q != ple_pkg::ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  assign val_in_ext  = EW'($unsigned(in_beat_i.value));
  assign elem_ext    = EW'($signed(mem_rdata_q));
  assign pos_in_w    = WW'(in_beat_i.position);
  assign count_w     = WW'(count_q);
  assign cur_greater = $signed(cur_q) > $signed(mem_rdata_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr[AW-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    pos_q      <= pos_d;
    fpos_q     <= fpos_d;
    val_q      <= val_d;
    cur_q      <= cur_d;
    status_q   <= status_d;
    out_beat_q <= out_beat_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    pos_d       = pos_q;
    fpos_d      = fpos_q;
    val_d       = val_q;
    cur_d       = cur_q;
    status_d    = status_q;
    out_beat_d  = out_beat_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = i_q;
    mem_raddr   = i_q;
    mem_wdata   = mem_rdata_q;

    case (state_q)
      ple_pkg::ST_IDLE: begin
        if (in_take) begin
          val_d    = val_in_ext[VALUE_WIDTH-1:0];
          status_d = ple_pkg::STAT_OK;
          fpos_d   = '0;
          state_d  = ple_pkg::ST_DONE;
          case (ple_pkg::req_e'(in_beat_i.req_type))
            ple_pkg::REQ_APPEND: begin
              if (count_q == CW'(DEPTH)) begin
                status_d = ple_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q;
                mem_wdata = val_in_ext[VALUE_WIDTH-1:0];
                count_d   = count_q + 1'b1;
              end
            end
            ple_pkg::REQ_INSERT: begin
              if (pos_in_w == '0 || pos_in_w > count_w + 1'b1) begin
                status_d = ple_pkg::STAT_BAD_POS;
              end else if (count_q == CW'(DEPTH)) begin
                status_d = ple_pkg::STAT_FULL;
              end else begin
                pos_d   = CW'(in_beat_i.position);
                i_d     = count_q;
                state_d = ple_pkg::ST_INS_RD;
              end
            end
            ple_pkg::REQ_DELETE: begin
              if (pos_in_w == '0 || pos_in_w > count_w) begin
                status_d = ple_pkg::STAT_BAD_POS;
              end else begin
                i_d     = CW'(in_beat_i.position) - 1'b1;
                state_d = ple_pkg::ST_DEL_RD;
              end
            end
            ple_pkg::REQ_LOCATE: begin
              i_d     = '0;
              state_d = ple_pkg::ST_LOC_RD;
            end
            ple_pkg::REQ_SORT: begin
              i_d     = '0;
              state_d = ple_pkg::ST_SRT_I;
            end
            ple_pkg::REQ_SHOW: begin
              if (count_q != '0) begin
                i_d     = '0;
                state_d = ple_pkg::ST_SHW_RD;
              end
            end
            ple_pkg::REQ_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ple_pkg::ST_INS_RD: begin
        if (i_q >= pos_q) begin
          mem_re    = 1'b1;
          mem_raddr = i_q - 1'b1;
          state_d   = ple_pkg::ST_INS_WR;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pos_q - 1'b1;
          mem_wdata = val_q;
          count_d   = count_q + 1'b1;
          state_d   = ple_pkg::ST_DONE;
        end
      end
      ple_pkg::ST_INS_WR: begin
        mem_we  = 1'b1;
        i_d     = i_q - 1'b1;
        state_d = ple_pkg::ST_INS_RD;
      end
      ple_pkg::ST_DEL_RD: begin
        if (i_q + 1'b1 < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = i_q + 1'b1;
          state_d   = ple_pkg::ST_DEL_WR;
        end else begin
          count_d = count_q - 1'b1;
          state_d = ple_pkg::ST_DONE;
        end
      end
      ple_pkg::ST_DEL_WR: begin
        mem_we  = 1'b1;
        i_d     = i_q + 1'b1;
        state_d = ple_pkg::ST_DEL_RD;
      end
      ple_pkg::ST_LOC_RD: begin
        if (i_q < count_q) begin
          mem_re  = 1'b1;
          state_d = ple_pkg::ST_LOC_CMP;
        end else begin
          status_d = ple_pkg::STAT_NOT_FOUND;
          state_d  = ple_pkg::ST_DONE;
        end
      end
      ple_pkg::ST_LOC_CMP: begin
        if (mem_rdata_q == val_q) begin
          fpos_d  = i_q + 1'b1;
          state_d = ple_pkg::ST_DONE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ple_pkg::ST_LOC_RD;
        end
      end
      ple_pkg::ST_SRT_I: begin
        if (i_q + 1'b1 < count_q) begin
          mem_re  = 1'b1;
          state_d = ple_pkg::ST_SRT_LD;
        end else begin
          state_d = ple_pkg::ST_DONE;
        end
      end
      ple_pkg::ST_SRT_LD: begin
        cur_d   = mem_rdata_q;
        j_d     = i_q + 1'b1;
        state_d = ple_pkg::ST_SRT_RD;
      end
      ple_pkg::ST_SRT_RD: begin
        if (j_q < count_q) begin
          mem_re    = 1'b1;
          mem_raddr = j_q;
          state_d   = ple_pkg::ST_SRT_CMP;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = cur_q;
          i_d       = i_q + 1'b1;
          state_d   = ple_pkg::ST_SRT_I;
        end
      end
      ple_pkg::ST_SRT_CMP: begin
        if (cur_greater) begin
          mem_we    = 1'b1;
          mem_waddr = j_q;
          mem_wdata = cur_q;
          cur_d     = mem_rdata_q;
        end
        j_d     = j_q + 1'b1;
        state_d = ple_pkg::ST_SRT_RD;
      end
      ple_pkg::ST_SHW_RD: begin
        mem_re  = 1'b1;
        state_d = ple_pkg::ST_SHW_EMIT;
      end
      ple_pkg::ST_SHW_EMIT: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_beat_d.status         = ple_pkg::STAT_OK;
          out_beat_d.found_position = ple_pkg::POS_W'(i_q + 1'b1);
          out_beat_d.element        = elem_ext[ple_pkg::VAL_W-1:0];
          out_beat_d.length         = ple_pkg::LEN_W'(count_q);
          out_beat_d.last           = (i_q + 1'b1 == count_q);
          i_d                       = i_q + 1'b1;
          state_d = (i_q + 1'b1 == count_q) ? ple_pkg::ST_IDLE : ple_pkg::ST_SHW_RD;
        end
      end
      ple_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_beat_d.status         = status_q;
          out_beat_d.found_position = ple_pkg::POS_W'(fpos_q);
          out_beat_d.element        = '0;
          out_beat_d.length         = ple_pkg::LEN_W'(count_q);
          out_beat_d.last           = 1'b1;
          state_d                   = ple_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ple_pkg::ST_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("List count exceeds the store depth.");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr < CW'(DEPTH)))
    else $error("Element write outside the store.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1 || count_q == '0))
    else $error("List count changed by more than one element.");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_stall_o)
    else $error("Request taken without the engine turning busy.");

  a_result_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !(out_valid_q && out_stall_i)) |-> in_stall_o)
    else $error("Result beat loaded while the engine was idle.");

endmodule
